### design/takf_pkg.sv
// shared types, fixed-point constants and saturation helpers for the tilt filter
// no dependencies; every other file imports this package
package takf_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int WIDE_W     = DATA_WIDTH + 2;

  localparam int ACC_W   = 25;
  localparam int GYR_W   = 28;
  localparam int OUT_W   = 32;
  localparam int APN_W   = 17;
  localparam int BPN_W   = 17;
  localparam int MN_W    = 23;
  localparam int DT_W    = 17;
  localparam int CFG_DW  = 23;
  localparam int CFG_IW  = 2;

  typedef logic signed [DATA_WIDTH-1:0] dw_t;
  typedef logic signed [WIDE_W-1:0]     wide_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_APN = 2'd0,
    CFG_BPN = 2'd1,
    CFG_MN  = 2'd2,
    CFG_DT  = 2'd3
  } cfg_idx_e;

  localparam wide_t SMAX_W = (wide_t'(1) <<< (DATA_WIDTH - 1)) - wide_t'(1);
  localparam wide_t SMIN_W = -SMAX_W - wide_t'(1);
  localparam dw_t   ONE_Q  = dw_t'(1) <<< FRAC_BITS;

  typedef struct packed {
    logic start;
    dw_t  a;
    dw_t  b;
  } mul_req_t;

  typedef struct packed {
    logic start;
    dw_t  n;
    dw_t  d;
  } div_req_t;

  function automatic dw_t sat_dw(wide_t v);
    wide_t r;
    if (v > SMAX_W) r = SMAX_W;
    else if (v < SMIN_W) r = SMIN_W;
    else r = v;
    return r[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(wide_t v);
    logic signed [63:0] x;
    x = 64'(v);
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    else if (x < -64'sd2147483648) x = -64'sd2147483648;
    return x[OUT_W-1:0];
  endfunction

endpackage

### design/takf_if.sv
// sample and result channel interfaces, valid/ready with payload
// depends on takf_pkg
interface takf_in_if import takf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] accel_angle;
  logic signed [GYR_W-1:0] gyro_rate;
  modport source (output valid, accel_angle, gyro_rate, input ready);
  modport sink   (input valid, accel_angle, gyro_rate, output ready);
endinterface

interface takf_out_if import takf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] fused_angle;
  logic signed [OUT_W-1:0] corrected_rate;
  modport source (output valid, fused_angle, corrected_rate, input ready);
  modport sink   (input valid, fused_angle, corrected_rate, output ready);
endinterface

### design/takf_mul.sv
// shared fixed-point multiplier: registered product then registered result, rounds half away from zero, saturates
// depends on takf_pkg
module takf_mul import takf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output logic     done_o,
  output dw_t      res_o
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int QW = PW - FRAC_BITS;

  logic [DATA_WIDTH-1:0] ua, ub;
  logic [PW-1:0]         prod_d, prod_q;
  logic                  neg_q, v1_q;
  logic [PW-1:0]         rnd;
  logic [QW-1:0]         qmag;
  dw_t                   res_d;

  assign ua     = req_i.a[DATA_WIDTH-1] ? (~req_i.a + 1'b1) : req_i.a;
  assign ub     = req_i.b[DATA_WIDTH-1] ? (~req_i.b + 1'b1) : req_i.b;
  assign prod_d = PW'(ua) * PW'(ub);

  assign rnd  = prod_q + (PW'(1) << (FRAC_BITS - 1));
  assign qmag = rnd[PW-1:FRAC_BITS];

  always_comb begin
    if (neg_q) begin
      if (qmag > QW'(SMAX_W[DATA_WIDTH-1:0]) + QW'(1)) res_d = SMIN_W[DATA_WIDTH-1:0];
      else res_d = dw_t'(-qmag[DATA_WIDTH-1:0]);
    end else begin
      if (qmag > QW'(SMAX_W[DATA_WIDTH-1:0])) res_d = SMAX_W[DATA_WIDTH-1:0];
      else res_d = dw_t'(qmag[DATA_WIDTH-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q   <= req_i.start;
      done_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= prod_d;
      neg_q  <= req_i.a[DATA_WIDTH-1] ^ req_i.b[DATA_WIDTH-1];
    end
    if (v1_q) res_o <= res_d;
  end

endmodule

### design/takf_div.sv
// restoring divider for the gain, one quotient bit per cycle, truncates toward zero
// depends on takf_pkg; divisor must be positive
module takf_div import takf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output logic     done_o,
  output dw_t      res_o
);

  localparam int NW = DATA_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]         dvd_q;
  logic [DATA_WIDTH:0]   rem_q, rem_sh, rem_sub;
  logic [DATA_WIDTH-1:0] den_q, un;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q, neg_q;
  dw_t                   res_d;

  assign un      = req_i.n[DATA_WIDTH-1] ? (~req_i.n + 1'b1) : req_i.n;
  assign rem_sh  = {rem_q[DATA_WIDTH-1:0], dvd_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  // dvd_q holds the quotient once all bits have shifted through
  always_comb begin
    if (dvd_q > NW'(SMAX_W[DATA_WIDTH-1:0])) begin
      res_d = neg_q ? SMIN_W[DATA_WIDTH-1:0] : SMAX_W[DATA_WIDTH-1:0];
    end else begin
      res_d = neg_q ? dw_t'(-dvd_q[DATA_WIDTH-1:0]) : dw_t'(dvd_q[DATA_WIDTH-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= {un, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      den_q <= req_i.d;
      neg_q <= req_i.n[DATA_WIDTH-1];
    end else if (busy_q && cnt_q != '0) begin
      if (!rem_sub[DATA_WIDTH]) begin
        rem_q <= rem_sub;
        dvd_q <= {dvd_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        dvd_q <= {dvd_q[NW-2:0], 1'b0};
      end
    end
    if (busy_q && cnt_q == '0) res_o <= res_d;
  end

endmodule

### design/tilt_angle_kalman_fusion.sv
// two-state tilt Kalman filter: sequencer, state and config registers
// depends on takf_pkg, takf_if, takf_mul, takf_div
// Each sample runs ten products through the shared multiplier and two gain
// quotients through the bit-serial divider, one operation at a time, between
// accepting the input beat and loading the output register. When the
// innovation variance is not positive, both divides are skipped. The input is
// ready only while the sequencer is idle. A finished result waits in the
// output register, so the next sample can be taken before the previous result
// is consumed. Arithmetic is signed Q16.16, each product rounded half away from
// zero, each quotient truncated, and every intermediate saturated to 32 bits.
// Configuration writes are taken at once.
module tilt_angle_kalman_fusion import takf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  takf_in_if.sink           in_s,
  takf_out_if.source        out_s,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_e;
  typedef enum logic [3:0] {
    OP_RATE, OP_PD0, OP_CBB, OP_BPN, OP_DIV0, OP_DIV1,
    OP_K0T0, OP_K0T1, OP_K1T0, OP_K1T1, OP_K0E, OP_K1E
  } op_e;

  state_e state_q;
  op_e    op_q;

  logic [APN_W-1:0] apn_q;
  logic [BPN_W-1:0] bpn_q;
  logic [MN_W-1:0]  mn_q;
  logic [DT_W-1:0]  dt_q;

  dw_t ang_q, bias_q, caa_q, cab_q, cba_q, cbb_q;
  dw_t rate_q, err_q, e_q, t0_q, t1_q, k0_q, k1_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [GYR_W-1:0] gyr_q;

  mul_req_t mreq;
  div_req_t dreq;
  logic     mdone, ddone;
  dw_t      mres, dres, res;
  logic     is_div, done;
  dw_t      dt_w;

  logic                    ovalid_q;
  logic signed [OUT_W-1:0] ofused_q, orate_q;

  assign dt_w   = dw_t'(dt_q);
  assign is_div = (op_q == OP_DIV0) || (op_q == OP_DIV1);
  assign res    = is_div ? dres : mres;
  assign done   = is_div ? ddone : mdone;

  always_comb begin
    mreq = '0;
    dreq = '0;
    case (op_q)
      OP_RATE: begin mreq.a = rate_q; mreq.b = dt_w; end
      OP_PD0:  begin
        mreq.a = sat_dw(wide_t'(apn_q) - wide_t'(cab_q) - wide_t'(cba_q));
        mreq.b = dt_w;
      end
      OP_CBB:  begin mreq.a = sat_dw(-wide_t'(cbb_q)); mreq.b = dt_w; end
      OP_BPN:  begin mreq.a = dw_t'(bpn_q); mreq.b = dt_w; end
      OP_DIV0: begin dreq.n = t0_q; dreq.d = e_q; end
      OP_DIV1: begin dreq.n = cba_q; dreq.d = e_q; end
      OP_K0T0: begin mreq.a = k0_q; mreq.b = t0_q; end
      OP_K0T1: begin mreq.a = k0_q; mreq.b = t1_q; end
      OP_K1T0: begin mreq.a = k1_q; mreq.b = t0_q; end
      OP_K1T1: begin mreq.a = k1_q; mreq.b = t1_q; end
      OP_K0E:  begin mreq.a = k0_q; mreq.b = err_q; end
      OP_K1E:  begin mreq.a = k1_q; mreq.b = err_q; end
      default: ;
    endcase
    // a nonpositive innovation variance skips the divide and the gain is set to zero
    if (state_q == ST_ISSUE) begin
      if (is_div) dreq.start = (e_q > 0);
      else mreq.start = 1'b1;
    end
  end

  takf_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .done_o(mdone), .res_o(mres));
  takf_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .res_o(dres));

  assign in_s.ready           = (state_q == ST_IDLE);
  assign out_s.valid          = ovalid_q;
  assign out_s.fused_angle    = ofused_q;
  assign out_s.corrected_rate = orate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_RATE;
      ovalid_q <= 1'b0;
      apn_q    <= APN_W'(66);
      bpn_q    <= BPN_W'(197);
      mn_q     <= MN_W'(32768);
      dt_q     <= DT_W'(655);
      ang_q    <= '0;
      bias_q   <= '0;
      caa_q    <= ONE_Q;
      cab_q    <= '0;
      cba_q    <= '0;
      cbb_q    <= ONE_Q;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_APN: apn_q <= cfg_wdata_i[APN_W-1:0];
          CFG_BPN: bpn_q <= cfg_wdata_i[BPN_W-1:0];
          CFG_MN:  mn_q  <= cfg_wdata_i[MN_W-1:0];
          CFG_DT:  dt_q  <= cfg_wdata_i[DT_W-1:0];
          default: ;
        endcase
      end
      // in ST_OUT a consumed beat is replaced by the new one below
      if (ovalid_q && out_s.ready && state_q != ST_OUT) ovalid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_s.valid) begin
            acc_q   <= in_s.accel_angle;
            gyr_q   <= in_s.gyro_rate;
            rate_q  <= sat_dw(wide_t'(in_s.gyro_rate) - wide_t'(bias_q));
            op_q    <= OP_RATE;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (is_div && !(e_q > 0)) begin
            if (op_q == OP_DIV0) k0_q <= '0;
            else k1_q <= '0;
            op_q <= op_e'(op_q + 1'b1);
          end else begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (done) begin
            case (op_q)
              OP_RATE: ang_q <= sat_dw(wide_t'(ang_q) + wide_t'(res));
              OP_PD0:  caa_q <= sat_dw(wide_t'(caa_q) + wide_t'(res));
              OP_CBB: begin
                cab_q <= sat_dw(wide_t'(cab_q) + wide_t'(res));
                cba_q <= sat_dw(wide_t'(cba_q) + wide_t'(res));
              end
              OP_BPN: begin
                cbb_q <= sat_dw(wide_t'(cbb_q) + wide_t'(res));
                err_q <= sat_dw(wide_t'(acc_q) - wide_t'(ang_q));
                e_q   <= sat_dw(wide_t'(mn_q) + wide_t'(caa_q));
                t0_q  <= caa_q;
                t1_q  <= cab_q;
              end
              OP_DIV0: k0_q   <= res;
              OP_DIV1: k1_q   <= res;
              OP_K0T0: caa_q  <= sat_dw(wide_t'(caa_q) - wide_t'(res));
              OP_K0T1: cab_q  <= sat_dw(wide_t'(cab_q) - wide_t'(res));
              OP_K1T0: cba_q  <= sat_dw(wide_t'(cba_q) - wide_t'(res));
              OP_K1T1: cbb_q  <= sat_dw(wide_t'(cbb_q) - wide_t'(res));
              OP_K0E:  ang_q  <= sat_dw(wide_t'(ang_q) + wide_t'(res));
              OP_K1E:  bias_q <= sat_dw(wide_t'(bias_q) + wide_t'(res));
              default: ;
            endcase
            if (op_q == OP_K1E) begin
              state_q <= ST_OUT;
            end else begin
              op_q    <= op_e'(op_q + 1'b1);
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_OUT: begin
          // hold the beat until the output register frees up
          if (!ovalid_q || out_s.ready) begin
            ovalid_q <= 1'b1;
            ofused_q <= sat_out(wide_t'(ang_q));
            orate_q  <= sat_out(wide_t'(gyr_q) - wide_t'(bias_q));
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
